@@ hw/rtl/qsgd_pkg.sv @@
// Shared types, constants and helpers for the quadratic spline grid deposit block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package qsgd_pkg;

  localparam int ROWS_DEF    = 64;
  localparam int COLS_DEF    = 64;
  localparam int SPECIES_DEF = 4;

  localparam int ACC_W = 40;   // accumulator width, Q23.16
  localparam int WGT_W = 18;   // one axis weight, signed Q.16
  localparam int CW_W  = 34;   // cell weight, signed Q.32
  localparam int DLT_W = 33;   // increment after the charge magnitude is taken
  localparam int PRD_W = DLT_W + CW_W;
  localparam int INC_W = PRD_W - 32;

  localparam logic [1:0] MODE_IGNORE = 2'd3;

  typedef enum logic [1:0] {
    OP_CUR = 2'd0,
    OP_CHG = 2'd1,
    OP_RD  = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         cell_y;
    logic [6:0]         cell_z;
    logic [16:0]        frac_y;
    logic [16:0]        frac_z;
    logic [1:0]         species;
    logic signed [31:0] delta_jx;
    logic signed [31:0] delta_jy;
    logic signed [31:0] delta_jz;
    logic signed [31:0] delta_charge;
  } req_t;

  typedef struct packed {
    logic [11:0] layer_tag;
    acc_t        sum_jx;
    acc_t        sum_jy;
    acc_t        sum_jz;
    acc_t        sum_density;
  } rsp_t;

  // One classified item as the back end needs it.
  typedef struct packed {
    op_t                      op;
    logic [6:0]               cy;
    logic [6:0]               cz;
    logic [1:0]               sp;
    logic                     sp_ok;
    wgt_t [2:0]               wy;
    wgt_t [2:0]               wz;
    logic signed [DLT_W-1:0]  da;
    logic signed [DLT_W-1:0]  db;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bstat_t;

  function automatic acc_t sat_add(input acc_t acc, input logic signed [INC_W-1:0] inc);
    logic signed [ACC_W+1:0] sum;
    sum = (ACC_W+2)'(acc) + (ACC_W+2)'(inc);
    if (sum > $signed((ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}})))
      sat_add = {1'b0, {(ACC_W-1){1'b1}}};
    else if (sum < $signed({{3{1'b1}}, {(ACC_W-1){1'b0}}}))
      sat_add = {1'b1, {(ACC_W-1){1'b0}}};
    else
      sat_add = sum[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qsgd_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on qsgd_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none
module qsgd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire qsgd_pkg::cmd_t push_cmd,
  output logic               ready,
  input  wire logic          pop,
  output logic               valid,
  output qsgd_pkg::cmd_t     head
);
  import qsgd_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

@@ hw/rtl/qsgd_front.sv @@
// Front end: accepts items, clamps indices, forms the spline weights and pushes
// commands into the queue. Depends on qsgd_pkg and qsgd_queue.
`timescale 1ns / 1ps
`default_nettype none
module qsgd_front #(
  parameter int ROWS    = qsgd_pkg::ROWS_DEF,
  parameter int COLS    = qsgd_pkg::COLS_DEF,
  parameter int SPECIES = qsgd_pkg::SPECIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire qsgd_pkg::req_t req,
  input  wire logic           hold,
  input  wire logic           pop,
  output logic                cmd_valid,
  output qsgd_pkg::cmd_t      cmd
);
  import qsgd_pkg::*;

  // Weights in Q.16 from a Q.33 exact form, rounded half up.
  function automatic wgt_t [2:0] axis_weights(input logic [16:0] frac);
    logic [16:0]        f;
    logic signed [17:0] s;
    logic signed [35:0] s2;
    logic signed [35:0] sh;
    logic signed [35:0] t0;
    logic signed [35:0] t1;
    logic signed [35:0] t2;
    f  = (frac > 17'd65536) ? 17'd65536 : frac;
    s  = $signed({1'b0, f}) - 18'sd32768;
    s2 = 36'(s) * 36'(s);
    sh = 36'(s) <<< 16;
    t0 = (s2 - sh + 36'sd65536) >>> 17;
    t1 = (36'sd8589934592 - (s2 <<< 1) + 36'sd65536) >>> 17;
    t2 = (s2 + sh + 36'sd65536) >>> 17;
    axis_weights = {t2[WGT_W-1:0], t1[WGT_W-1:0], t0[WGT_W-1:0]};
  endfunction

  logic q_ready;
  logic push;
  cmd_t new_cmd;
  logic signed [DLT_W-1:0] q_abs;

  assign req_ready = q_ready && !hold;
  assign push      = req_valid && req_ready && (req.mode != MODE_IGNORE);
  assign q_abs     = req.delta_charge[31] ? -DLT_W'(req.delta_charge) : DLT_W'(req.delta_charge);

  always_comb begin
    new_cmd       = '0;
    new_cmd.op    = op_t'(req.mode);
    new_cmd.cy    = (32'(req.cell_y) > ROWS + 1) ? 7'(ROWS + 1) : req.cell_y;
    new_cmd.cz    = (32'(req.cell_z) > COLS + 1) ? 7'(COLS + 1) : req.cell_z;
    new_cmd.sp    = req.species;
    new_cmd.sp_ok = (32'(req.species) < SPECIES);
    new_cmd.wy    = axis_weights(req.frac_y);
    new_cmd.wz    = axis_weights(req.frac_z);
    if (req.mode == 2'(OP_CUR)) begin
      new_cmd.da = DLT_W'(req.delta_jy);
      new_cmd.db = DLT_W'(req.delta_jz);
    end else begin
      new_cmd.da = q_abs;
      new_cmd.db = DLT_W'(req.delta_jx);
    end
  end

  qsgd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (new_cmd),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (cmd_valid),
    .head     (cmd)
  );

endmodule
`default_nettype wire

@@ hw/rtl/qsgd_back.sv @@
// Back end: clears the stores after reset, then walks each command over its
// cells through a read, multiply, saturating-write pipeline. Depends on qsgd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qsgd_back #(
  parameter int ROWS    = qsgd_pkg::ROWS_DEF,
  parameter int COLS    = qsgd_pkg::COLS_DEF,
  parameter int SPECIES = qsgd_pkg::SPECIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire qsgd_pkg::cmd_t cmd,
  output logic                pop,
  input  wire logic [11:0]    layer,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output qsgd_pkg::rsp_t      rsp,
  output qsgd_pkg::bstat_t    stat
);
  import qsgd_pkg::*;

  localparam int PAD_COLS = COLS + 4;
  localparam int CELLS    = (ROWS + 4) * PAD_COLS;
  localparam int AW       = $clog2(CELLS);
  localparam int SW       = (SPECIES > 1) ? $clog2(SPECIES) : 1;

  typedef logic [SPECIES-1:0][ACC_W-1:0] drow_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  acc_t  jx_mem  [CELLS];
  acc_t  jy_mem  [CELLS];
  acc_t  jz_mem  [CELLS];
  drow_t den_mem [CELLS];

  state_t  state, state_next;
  logic [AW-1:0] clr_addr;
  cmd_t    cur;
  logic [1:0] ia, ib;

  logic    start, issue, last;
  logic [1:0] ya, zb;
  logic [AW-1:0] addr0;

  logic    v1, v2;
  logic [AW-1:0] addr1, addr2;
  logic signed [CW_W-1:0] w1;
  acc_t    rd_jx, rd_jy, rd_jz;
  drow_t   rd_den;
  acc_t    rx2, ry2, rz2;
  drow_t   rden2;
  logic signed [PRD_W-1:0] pa2, pb2;

  logic signed [PRD_W-1:0] sa, sb;
  logic signed [INC_W-1:0] inc_a, inc_b;
  logic [SW-1:0] spi;
  logic    clearing, is_rd, is_chg, is_cur;
  logic    we_jx, we_jyz, we_den;
  logic [AW-1:0] waddr;
  acc_t    wd_jx, wd_jy, wd_jz;
  drow_t   wd_den;

  assign clearing = (state == ST_CLEAR);
  assign is_rd    = (cur.op == OP_RD);
  assign is_chg   = (cur.op == OP_CHG);
  assign is_cur   = (cur.op == OP_CUR);
  assign spi      = SW'(cur.sp);

  assign start = (state == ST_IDLE) && cmd_valid && !v1 && !v2
                 && !((cmd.op == OP_RD) && rsp_valid);
  assign pop   = start;
  assign issue = (state == ST_RUN);
  assign last  = is_rd || (ia == 2'd2 && ib == 2'd2);

  assign stat.clearing = clearing;
  assign stat.busy     = issue || v1 || v2;

  // A read touches the centre cell only.
  assign ya    = is_rd ? 2'd1 : ia;
  assign zb    = is_rd ? 2'd1 : ib;
  assign addr0 = (AW'(cur.cy) + AW'(ya)) * AW'(PAD_COLS) + AW'(cur.cz) + AW'(zb);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (last) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + AW'(1);
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= cmd;
      ia  <= 2'd0;
      ib  <= 2'd0;
    end else if (issue) begin
      if (ib == 2'd2) begin
        ib <= 2'd0;
        ia <= ia + 2'd1;
      end else begin
        ib <= ib + 2'd1;
      end
    end
  end

  // Stage 1: cell weight and store read; stage 2: increments.
  always_ff @(posedge clk) begin
    addr1 <= addr0;
    w1    <= CW_W'($signed(cur.wy[ya]) * $signed(cur.wz[zb]));
    addr2 <= addr1;
    pa2   <= PRD_W'(cur.da) * PRD_W'(w1);
    pb2   <= PRD_W'(cur.db) * PRD_W'(w1);
    rx2   <= rd_jx;
    ry2   <= rd_jy;
    rz2   <= rd_jz;
    rden2 <= rd_den;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_jx  <= jx_mem[addr0];
      rd_jy  <= jy_mem[addr0];
      rd_jz  <= jz_mem[addr0];
      rd_den <= den_mem[addr0];
    end
  end

  assign sa    = pa2 + PRD_W'(64'sd2147483648);
  assign sb    = pb2 + PRD_W'(64'sd2147483648);
  assign inc_a = sa[PRD_W-1:32];
  assign inc_b = sb[PRD_W-1:32];

  always_comb begin
    we_jx  = clearing || (v2 && (is_chg || is_rd));
    we_jyz = clearing || (v2 && (is_cur || is_rd));
    we_den = clearing || (v2 && (is_chg || is_rd) && cur.sp_ok);
    waddr  = clearing ? clr_addr : addr2;
    wd_jx  = (clearing || is_rd) ? '0 : sat_add(rx2, inc_b);
    wd_jy  = (clearing || is_rd) ? '0 : sat_add(ry2, inc_a);
    wd_jz  = (clearing || is_rd) ? '0 : sat_add(rz2, inc_b);
    wd_den = rden2;
    if (clearing) wd_den = '0;
    else if (is_rd) wd_den[spi] = '0;
    else wd_den[spi] = sat_add(acc_t'(rden2[spi]), inc_a);
  end

  always_ff @(posedge clk) begin
    if (we_jx) jx_mem[waddr] <= wd_jx;
  end

  always_ff @(posedge clk) begin
    if (we_jyz) jy_mem[waddr] <= wd_jy;
  end

  always_ff @(posedge clk) begin
    if (we_jyz) jz_mem[waddr] <= wd_jz;
  end

  always_ff @(posedge clk) begin
    if (we_den) den_mem[waddr] <= wd_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (v2 && is_rd) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && is_rd) begin
      rsp.layer_tag   <= layer;
      rsp.sum_jx      <= rx2;
      rsp.sum_jy      <= ry2;
      rsp.sum_jz      <= rz2;
      rsp.sum_density <= cur.sp_ok ? acc_t'(rden2[spi]) : '0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/quadratic_spline_grid_deposit.sv @@
// Top level of the quadratic spline grid deposit block.
// Depends on qsgd_pkg, qsgd_front and qsgd_back.
//
// The req channel takes deposit, charge and read items (valid/ready). Deposit
// and charge items spread their increments over the 3x3 cells around the
// centre cell; a read item returns the centre cell on the rsp channel and
// clears it. Mode three items are taken and dropped.
// The front end classifies an item and forms its weights in the cycle it is
// accepted and parks it in a two-entry queue. The back end owns the single
// write port of each store: a deposit or charge item issues its cells one a
// cycle, then drains its three-stage read, multiply, write pipeline before
// the next item starts.
// After reset the back end zeroes every store entry, one cell per cycle;
// req_ready stays low meanwhile. cfg_we writes the layer register, which is
// echoed in read results.
// The rsp register holds a result until it is taken; a stalled receiver
// holds the next read at the head of the queue, and the items behind it wait.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_spline_grid_deposit #(
  parameter int ROWS    = qsgd_pkg::ROWS_DEF,
  parameter int COLS    = qsgd_pkg::COLS_DEF,
  parameter int SPECIES = qsgd_pkg::SPECIES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire qsgd_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output qsgd_pkg::rsp_t      rsp,
  input  wire logic           cfg_we,
  input  wire logic [11:0]    cfg_data
);
  import qsgd_pkg::*;

  logic [11:0] current_layer;
  logic        cmd_valid;
  logic        pop;
  cmd_t        cmd;
  bstat_t      bstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_layer <= '0;
    end else if (cfg_we) begin
      current_layer <= cfg_data;
    end
  end

  qsgd_front #(.ROWS(ROWS), .COLS(COLS), .SPECIES(SPECIES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .hold      (bstat.clearing),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  qsgd_back #(.ROWS(ROWS), .COLS(COLS), .SPECIES(SPECIES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .layer     (current_layer),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .stat      (bstat)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !req_ready) else $error("item accepted during store clear");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !bstat.clearing) else $error("result during store clear");

  a_result_from_pipeline: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(bstat.busy)) else $error("result without back-end work");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for quadratic_spline_grid_deposit.
// Depends on qsgd_pkg and the block's RTL; predicts read results from a local grid model.
`timescale 1ns / 1ps
module tb_top;
  import qsgd_pkg::*;

  localparam int NR = 64;
  localparam int NC = 64;
  localparam int NSP = 4;
  localparam int PC = NC + 4;
  localparam int NCELL = (NR + 4) * PC;
  localparam int IDLE_LIMIT = 20000;

  typedef logic signed [39:0] acc40_t;

  class grid_scoreboard;
    acc40_t jx[NCELL];
    acc40_t jy[NCELL];
    acc40_t jz[NCELL];
    acc40_t dens[NSP][NCELL];
    logic [11:0] layer;
    rsp_t pending[$];
    int errors;
    int reads_checked;

    function void clear_all();
      for (int i = 0; i < NCELL; i++) begin
        jx[i] = 0; jy[i] = 0; jz[i] = 0;
        for (int s = 0; s < NSP; s++) dens[s][i] = 0;
      end
      layer = 0;
      errors = 0;
      reads_checked = 0;
    endfunction

    function longint fdiv(longint v, int n);
      // Arithmetic shift is floor division for both signs.
      return v >>> n;
    endfunction

    function void spline(input logic [16:0] frac, output longint w[3]);
      longint f, s, s2;
      f = frac;
      if (f > 65536) f = 65536;
      s = f - 32768;
      s2 = s * s;
      w[0] = fdiv(s2 - s * 65536 + 65536, 17);
      w[1] = fdiv((longint'(1) <<< 33) - 2 * s2 + 65536, 17);
      w[2] = fdiv(s2 + s * 65536 + 65536, 17);
    endfunction

    function acc40_t accumulate(acc40_t acc, longint delta, longint wt);
      longint inc, v;
      inc = fdiv(delta * wt + (longint'(1) <<< 31), 32);
      v = longint'(acc) + inc;
      if (v > 64'sd549755813887) v = 64'sd549755813887;
      if (v < -64'sd549755813888) v = -64'sd549755813888;
      return v[39:0];
    endfunction

    function void note_item(req_t r);
      int cy, cz, addr;
      bit sp_ok;
      longint wy[3], wz[3], q;
      rsp_t e;
      cy = r.cell_y > NR + 1 ? NR + 1 : r.cell_y;
      cz = r.cell_z > NC + 1 ? NC + 1 : r.cell_z;
      sp_ok = r.species < NSP;
      if (r.mode == OP_NOP) return;
      if (r.mode == OP_RD) begin
        addr = (cy + 1) * PC + cz + 1;
        e.layer_tag = layer;
        e.sum_jx = jx[addr];
        e.sum_jy = jy[addr];
        e.sum_jz = jz[addr];
        e.sum_density = sp_ok ? dens[r.species][addr] : '0;
        if (sp_ok) dens[r.species][addr] = 0;
        jx[addr] = 0; jy[addr] = 0; jz[addr] = 0;
        pending.push_back(e);
        return;
      end
      spline(r.frac_y, wy);
      spline(r.frac_z, wz);
      q = longint'(r.delta_charge);
      if (q < 0) q = -q;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) begin
          addr = (cy + a) * PC + cz + b;
          if (r.mode == OP_CUR) begin
            jy[addr] = accumulate(jy[addr], r.delta_jy, wy[a] * wz[b]);
            jz[addr] = accumulate(jz[addr], r.delta_jz, wy[a] * wz[b]);
          end else begin
            if (sp_ok) dens[r.species][addr] = accumulate(dens[r.species][addr], q,
                                                          wy[a] * wz[b]);
            jx[addr] = accumulate(jx[addr], r.delta_jx, wy[a] * wz[b]);
          end
        end
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no read waiting", 0, 0);
        return;
      end
      e = pending.pop_front();
      reads_checked++;
      if (got.layer_tag !== e.layer_tag) report_mismatch("layer_tag", got.layer_tag, e.layer_tag);
      if (got.sum_jx !== e.sum_jx) report_mismatch("sum_jx", got.sum_jx, e.sum_jx);
      if (got.sum_jy !== e.sum_jy) report_mismatch("sum_jy", got.sum_jy, e.sum_jy);
      if (got.sum_jz !== e.sum_jz) report_mismatch("sum_jz", got.sum_jz, e.sum_jz);
      if (got.sum_density !== e.sum_density)
        report_mismatch("sum_density", got.sum_density, e.sum_density);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 50) $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  logic cfg_we = 0;
  logic [11:0] cfg_data = '0;

  grid_scoreboard grid;
  int idle_cycles = 0;
  int items_sent = 0;
  bit stall_mode = 0;

  always #5 clk = ~clk;

  quadratic_spline_grid_deposit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) grid.note_item(req);
    if (!rst && rsp_valid && rsp_ready) grid.check_result(rsp);
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("quadratic_spline_grid_deposit test failed");
      $finish;
    end
  end

  // Receiver stalls: a free-running pattern, at times with long stretches of readiness.
  always @(negedge clk) begin
    if (stall_mode) begin
      rsp_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      rsp_ready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
  end

  task automatic send_item(req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic pause_sender();
    req_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  function automatic req_t rand_item();
    req_t r;
    int pick;
    r.mode = op_t'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.mode = OP_NOP;
    r.cell_y = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 10));
    r.cell_z = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 10));
    r.frac_y = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65536, 131071))
                                            : 17'($urandom_range(0, 65536));
    r.frac_z = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65536, 131071))
                                            : 17'($urandom_range(0, 65536));
    r.species = 2'($urandom_range(0, 3));
    r.delta_jx = $urandom();
    r.delta_jy = $urandom();
    r.delta_jz = $urandom();
    r.delta_charge = $urandom();
    if ($urandom_range(0, 1)) begin
      // Moderate increments keep most sums away from saturation.
      r.delta_jx = $signed(r.delta_jx) >>> 8;
      r.delta_jy = $signed(r.delta_jy) >>> 8;
      r.delta_jz = $signed(r.delta_jz) >>> 8;
      r.delta_charge = $signed(r.delta_charge) >>> 8;
    end
    return r;
  endfunction

  task automatic drain_and_write(logic [11:0] value);
    req_valid <= 1'b0;
    while (grid.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    grid.layer = value;
  endtask

  task automatic directed_items();
    req_t r;
    logic [16:0] fr[4] = '{17'd0, 17'd32768, 17'd65536, 17'h1FFFF};
    for (int i = 0; i < 4; i++) begin
      r = '0;
      r.mode = OP_CUR; r.cell_y = 5; r.cell_z = 5; r.frac_y = fr[i]; r.frac_z = fr[3 - i];
      r.delta_jy = 32'sh7FFFFFFF; r.delta_jz = 32'sh80000000;
      send_item(r);
    end
    r = '0; r.mode = OP_CHG; r.cell_y = 5; r.cell_z = 5; r.frac_y = 17'd1000;
    r.frac_z = 17'd60000; r.species = 2; r.delta_charge = 32'sh80000000;
    r.delta_jx = 32'sh80000000;
    send_item(r);
    r.species = 3; r.delta_charge = -32'sd12345; r.delta_jx = 32'sh7FFFFFFF;
    send_item(r);
    // Deposit repeatedly into one cell with large increments.
    for (int i = 0; i < 6; i++) begin
      r = '0; r.mode = OP_CUR; r.cell_y = 1; r.cell_z = 1; r.frac_y = 32768;
      r.frac_z = 32768; r.delta_jy = 32'sh7FFFFFFF; r.delta_jz = 32'sh80000000;
      send_item(r);
    end
    r = '0; r.mode = OP_RD; r.cell_y = 1; r.cell_z = 1; send_item(r);
    r.cell_y = 5; r.cell_z = 5; r.species = 2; send_item(r);
    r.cell_y = 6; r.species = 3; send_item(r);
    r.cell_y = 127; r.cell_z = 127; r.species = 1; send_item(r);
    r.cell_y = 0; r.cell_z = 0; send_item(r);
    r.cell_y = 65; r.cell_z = 65; send_item(r);
    r = '1; r.mode = OP_NOP; send_item(r);
    r = '0; r.mode = OP_CHG; r.cell_y = 127; r.cell_z = 127; r.species = 1;
    r.frac_y = 17'h1FFFF; r.delta_charge = 32'sd99999; r.delta_jx = -32'sd7;
    send_item(r);
    r = '0; r.mode = OP_RD; r.cell_y = 65; r.cell_z = 65; r.species = 1; send_item(r);
  endtask

  task automatic random_phase(int count);
    int burst;
    int done;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && done < count; i++) begin
        send_item(rand_item());
        done++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
  endtask

  initial begin
    grid = new();
    grid.clear_all();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain_and_write(12'd0);
    directed_items();
    drain_and_write(12'hFFF);
    random_phase(500);
    drain_and_write(12'h5A3);
    random_phase(500);
    drain_and_write(12'd1);
    random_phase(500);
    req_valid <= 1'b0;
    while (grid.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d items over four layer settings; %0d read results checked.",
             items_sent, grid.reads_checked);
    if (grid.errors == 0) begin
      $display("quadratic_spline_grid_deposit test passed");
    end else begin
      $display("quadratic_spline_grid_deposit test failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/qsgd_pkg.sv
hw/rtl/qsgd_queue.sv
hw/rtl/qsgd_front.sv
hw/rtl/qsgd_back.sv
hw/rtl/quadratic_spline_grid_deposit.sv
dv/tb_top.sv
